/* rtl/framebuffer_dirty_strip_detector_core_macros.svh */
// Assertion macros for the dirty strip detector.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef FRAMEBUFFER_DIRTY_STRIP_DETECTOR_CORE_MACROS_SVH
`define FRAMEBUFFER_DIRTY_STRIP_DETECTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FBDSD_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fbdsd: invariant violated");
`define FBDSD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbdsd: implication violated");
`define FBDSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbdsd: next-cycle implication violated");
`else
`define FBDSD_ASSERT(label, cond)
`define FBDSD_ASSERT_IMPL(label, ante, cons)
`define FBDSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/fbdsd_pkg.sv */
package fbdsd_pkg;

	localparam int STRIP_COUNT    = 15;
	localparam int ROWS_PER_STRIP = 16;
	localparam int MAX_ROW_BYTES  = 4096;

	localparam int STRIDE_W  = 13;
	localparam int BYTE_W    = 8;
	localparam int HASH_W    = 32;
	localparam int OUT_ROW_W = 8;

	localparam int IDX_W  = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;
	localparam int CNT_W  = $clog2(STRIP_COUNT + 1);
	localparam int LEN_W  = $clog2(MAX_ROW_BYTES * ROWS_PER_STRIP + 1);
	localparam int PROD_W = 16;

	localparam logic [HASH_W-1:0]   HASH_BASIS   = 32'd2166136261;
	localparam logic [HASH_W-1:0]   HASH_PRIME   = 32'd16777619;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;
	localparam logic [IDX_W-1:0]    LAST_STRIP   = IDX_W'(STRIP_COUNT - 1);

	// One FNV-1a round: xor the byte in, multiply by the prime modulo 2^32.
	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
			input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
		return x * HASH_PRIME;
	endfunction

	// Clamp the stride and turn it into a strip length in bytes.
	function automatic logic [LEN_W-1:0] strip_len(input logic [STRIDE_W-1:0] s);
		logic [31:0] st;
		logic [31:0] len;
		st = {{(32-STRIDE_W){1'b0}}, s};
		if (st == 32'd0)
			st = 32'd1;
		if (st > 32'(MAX_ROW_BYTES))
			st = 32'(MAX_ROW_BYTES);
		len = st * 32'(ROWS_PER_STRIP);
		return len[LEN_W-1:0];
	endfunction

	// Strip count to rows, masked to the output width.
	function automatic logic [OUT_ROW_W-1:0] to_rows(input logic [CNT_W-1:0] n);
		logic [PROD_W-1:0] p;
		p = PROD_W'(n) * PROD_W'(ROWS_PER_STRIP);
		return p[OUT_ROW_W-1:0];
	endfunction

endpackage

/* rtl/fbdsd_if.sv */
interface fbdsd_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [fbdsd_pkg::BYTE_W-1:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink (input valid, input pixel_byte, output ready);
endinterface

interface fbdsd_region_if;
	logic                            valid;
	logic                            ready;
	logic [fbdsd_pkg::OUT_ROW_W-1:0] region_row;
	logic [fbdsd_pkg::OUT_ROW_W-1:0] region_rows;
	logic                            frame_end;

	modport source (output valid, output region_row, output region_rows, output frame_end,
		input ready);
	modport sink (input valid, input region_row, input region_rows, input frame_end,
		output ready);
endinterface

/* rtl/framebuffer_dirty_strip_detector_core.sv */
// Dirty strip detector for a frame buffer byte stream.
// pixel (sink): one frame buffer byte per item, raster order, valid/ready.
// region (source): one item per closed run of changed strips: first row,
//   row count (multiple of sixteen) and frame_end when the frame end closed it.
// cfg_we/cfg_wdata: row stride in bytes; write only while the block is idle.
//   A stride of 0 acts as 1, above 4096 acts as 4096.
// Throughput: one byte per cycle while the output register drains. The strip
//   hash is a combinational FNV-1a round (xor, then multiply by the prime),
//   which is the loop that sets the rate. Previous-frame hashes sit in a 15-entry
//   synchronous memory that is read continuously at the current strip and
//   written at strip end. Path: the byte that ends the closing strip loads the
//   compare stage when it is accepted; the compare stage loads the output register
//   once that has room, and region.valid rises as the output register loads.
// Stall: the output register holds a result while region.ready is low. The next
//   strip end, whether it reports a run or not, then waits in the compare stage
//   and the byte after it is held off until the register drains.
// Reset: hash restarts at the offset basis, counters and run state clear,
//   stride returns to 640 and every strip of the first frame counts as changed.
`include "framebuffer_dirty_strip_detector_core_macros.svh"

module framebuffer_dirty_strip_detector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	fbdsd_pixel_if.sink                         pixel,
	fbdsd_region_if.source                      region,
	input  logic                                cfg_we,
	input  logic [fbdsd_pkg::STRIDE_W-1:0]      cfg_wdata
);

	// Strip hash history: one entry per strip, written at strip end.
	logic [fbdsd_pkg::HASH_W-1:0] hist_mem [fbdsd_pkg::STRIP_COUNT];
	logic [fbdsd_pkg::HASH_W-1:0] hist_rd_q;

	// Byte stage state.
	logic [fbdsd_pkg::LEN_W-1:0]  strip_len_q;
	logic [fbdsd_pkg::LEN_W-1:0]  byte_cnt_q;
	logic [fbdsd_pkg::HASH_W-1:0] hash_q;
	logic [fbdsd_pkg::IDX_W-1:0]  strip_idx_q;
	logic                         hist_valid_q;

	// Strip-end compare stage.
	logic                         valid_s1;
	logic [fbdsd_pkg::HASH_W-1:0] hash_s1;
	logic [fbdsd_pkg::HASH_W-1:0] prev_s1;
	logic [fbdsd_pkg::IDX_W-1:0]  idx_s1;
	logic                         hv_s1;

	// Run tracking.
	logic                         run_open_q;
	logic [fbdsd_pkg::IDX_W-1:0]  run_start_q;

	// Output register.
	logic                            out_valid_q;
	logic [fbdsd_pkg::OUT_ROW_W-1:0] out_row_q;
	logic [fbdsd_pkg::OUT_ROW_W-1:0] out_rows_q;
	logic                            out_fe_q;

	logic                         in_acc;
	logic                         s1_go;
	logic [fbdsd_pkg::HASH_W-1:0] hash_next;
	logic [fbdsd_pkg::LEN_W:0]    cnt_inc;
	logic                         strip_end;
	logic                         end_acc;

	logic                         changed;
	logic                         nx_open;
	logic [fbdsd_pkg::IDX_W-1:0]  nx_start;
	logic                         emit;
	logic [fbdsd_pkg::IDX_W-1:0]  emit_start;
	logic [fbdsd_pkg::CNT_W-1:0]  emit_cnt;
	logic                         emit_fe;

	// The compare stage moves on when the output register has room for a result.
	assign s1_go        = valid_s1 && (!out_valid_q || region.ready);
	assign pixel.ready  = !valid_s1 || s1_go;
	assign in_acc       = pixel.valid && pixel.ready;

	assign hash_next = fbdsd_pkg::fnv_step(hash_q, pixel.pixel_byte);
	assign cnt_inc   = {1'b0, byte_cnt_q} + {{fbdsd_pkg::LEN_W{1'b0}}, 1'b1};
	// A stride change mid-strip may leave the count past the new length: end now.
	assign strip_end = cnt_inc >= {1'b0, strip_len_q};
	assign end_acc   = in_acc && strip_end;

	assign region.valid       = out_valid_q;
	assign region.region_row  = out_row_q;
	assign region.region_rows = out_rows_q;
	assign region.frame_end   = out_fe_q;

	// History memory: continuous read at the current strip, write at strip end.
	always_ff @(posedge clk) begin
		if (end_acc)
			hist_mem[strip_idx_q] <= hash_next;
		hist_rd_q <= hist_mem[strip_idx_q];
	end

	// Byte stage: fold the byte into the hash, count, close the strip.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_len_q  <= fbdsd_pkg::strip_len(fbdsd_pkg::STRIDE_RESET);
			byte_cnt_q   <= '0;
			hash_q       <= fbdsd_pkg::HASH_BASIS;
			strip_idx_q  <= '0;
			hist_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we)
				strip_len_q <= fbdsd_pkg::strip_len(cfg_wdata);
			if (s1_go)
				valid_s1 <= 1'b0;
			if (in_acc) begin
				if (strip_end) begin
					byte_cnt_q <= '0;
					hash_q     <= fbdsd_pkg::HASH_BASIS;
					valid_s1   <= 1'b1;
					if (strip_idx_q == fbdsd_pkg::LAST_STRIP) begin
						strip_idx_q  <= '0;
						hist_valid_q <= 1'b1;
					end else begin
						strip_idx_q <= strip_idx_q + 1'b1;
					end
				end else begin
					byte_cnt_q <= cnt_inc[fbdsd_pkg::LEN_W-1:0];
					hash_q     <= hash_next;
				end
			end
		end
	end

	// Capture the finished strip for the compare stage.
	always_ff @(posedge clk) begin
		if (end_acc) begin
			hash_s1 <= hash_next;
			prev_s1 <= hist_rd_q;
			idx_s1  <= strip_idx_q;
			hv_s1   <= hist_valid_q;
		end
	end

	// Compare stage: decide changed, open or close the run.
	always_comb begin
		changed    = !hv_s1 || (hash_s1 != prev_s1);
		nx_open    = run_open_q;
		nx_start   = run_start_q;
		emit       = 1'b0;
		emit_start = run_start_q;
		emit_cnt   = fbdsd_pkg::CNT_W'(idx_s1) - fbdsd_pkg::CNT_W'(run_start_q);
		emit_fe    = 1'b0;
		if (changed && !run_open_q) begin
			nx_open  = 1'b1;
			nx_start = idx_s1;
		end else if (!changed && run_open_q) begin
			emit    = 1'b1;
			nx_open = 1'b0;
		end
		// Frame end closes whatever run is still open, even one opened just now.
		if (idx_s1 == fbdsd_pkg::LAST_STRIP && nx_open) begin
			emit       = 1'b1;
			emit_start = nx_start;
			emit_cnt   = fbdsd_pkg::CNT_W'(fbdsd_pkg::STRIP_COUNT) -
				fbdsd_pkg::CNT_W'(nx_start);
			emit_fe    = 1'b1;
			nx_open    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q  <= 1'b0;
			run_start_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (region.ready)
				out_valid_q <= 1'b0;
			if (s1_go) begin
				run_open_q  <= nx_open;
				run_start_q <= nx_start;
				if (emit)
					out_valid_q <= 1'b1;
			end
		end
	end

	// Output payload: load only when a result moves in.
	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			out_row_q  <= fbdsd_pkg::to_rows(fbdsd_pkg::CNT_W'(emit_start));
			out_rows_q <= fbdsd_pkg::to_rows(emit_cnt);
			out_fe_q   <= emit_fe;
		end
	end

	// Strips are at least sixteen bytes long: strip ends never come back to back.
	`FBDSD_ASSERT_NEXT(a_end_spacing, end_acc, !end_acc)
	// No run survives the frame end once the last strip is resolved.
	`FBDSD_ASSERT_IMPL(a_run_closed_at_frame, (strip_idx_q == '0) && !valid_s1, !run_open_q)
	// Every reported run covers at least one strip.
	`FBDSD_ASSERT_IMPL(a_run_nonempty, s1_go && emit, emit_cnt != '0)
	// A result in the compare stage must never overwrite an undrained output.
	`FBDSD_ASSERT_IMPL(a_no_overwrite, s1_go && emit && out_valid_q, region.ready)
	// The byte count stays inside the largest strip.
	`FBDSD_ASSERT(a_cnt_range, byte_cnt_q <
		fbdsd_pkg::LEN_W'(fbdsd_pkg::MAX_ROW_BYTES * fbdsd_pkg::ROWS_PER_STRIP))

endmodule
